// File: rtl/core/tbmg_pkg.sv
// Package for the tessellated box mesh generator: field widths, codes, helpers.
// No dependencies.
package tbmg_pkg;
	localparam int FracBits = 8;
	localparam int MaxVertices = 65535;
	localparam int CfgIdxW = 3;
	localparam int DivW = 24;

	localparam logic [2:0] REG_SIZE_X = 3'd0;
	localparam logic [2:0] REG_SIZE_Y = 3'd1;
	localparam logic [2:0] REG_SIZE_Z = 3'd2;
	localparam logic [2:0] REG_TESS = 3'd3;
	localparam logic [2:0] REG_TEX = 3'd4;
	localparam logic [2:0] REG_INSIDE = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO_SIZE = 2'd1;
	localparam logic [1:0] ST_LOW_COUNT = 2'd2;
	localparam logic [1:0] ST_TOO_MANY = 2'd3;

	typedef struct packed {
		logic kind;
		logic [1:0] status;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] pos_z;
		logic [1:0] normal_axis;
		logic normal_sign;
		logic [15:0] tex_u;
		logic [15:0] tex_v;
		logic [15:0] index_value;
		logic last;
	} elem_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;     // capture registers, reset counters
		logic err;       // emit error word
		logic start_div; // begin vertex divisions
		logic emit_vtx;  // build vertex word from quotients
		logic emit_idx;  // build index word and advance
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] status;
		logic div_done;
		logic phase_idx;
	} sts_t;

	function automatic logic [15:0] sat16(input logic signed [18:0] p);
		if (p > 19'sd32767) return 16'h7fff;
		if (p < -19'sd32768) return 16'h8000;
		return p[15:0];
	endfunction
endpackage

// File: rtl/core/tbmg_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tbmg_pkg.
module tbmg_div import tbmg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DivW-1:0] dividend,
	input logic [7:0] divisor,
	output logic busy,
	output logic [DivW-1:0] quotient
);
	logic [DivW-1:0] q_q;
	logic [8:0] r_q;
	logic [7:0] d_q;
	logic [4:0] cnt_q;
	logic [9:0] trial;

	assign trial = {r_q, q_q[DivW-1]} - {2'b0, d_q};
	assign busy = cnt_q != 5'd0;
	assign quotient = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'(DivW);
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy) begin
			if (!trial[9]) begin
				r_q <= trial[8:0];
				q_q <= {q_q[DivW-2:0], 1'b1};
			end else begin
				r_q <= {r_q[7:0], q_q[DivW-1]};
				q_q <= {q_q[DivW-2:0], 1'b0};
			end
		end
	end
endmodule

// File: rtl/core/tbmg_dp.sv
// Datapath: latched configuration, loop counters, shared divider, output word.
// Depends on tbmg_pkg and tbmg_div.
module tbmg_dp import tbmg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [15:0] size_x,
	input logic [15:0] size_y,
	input logic [15:0] size_z,
	input logic [23:0] tess_counts,
	input logic [47:0] tex_scale,
	input logic inside_out,
	input cmd_t cmd,
	output sts_t sts,
	output elem_t elem,
	output logic done
);
	logic [15:0] sz_q [3];
	logic [7:0] ts_q [3];
	logic [15:0] tx_q [3];
	logic inside_q;
	logic [2:0] face_q, corner_q;
	logic phase_q;
	logic [7:0] ci_q, cj_q;
	logic [15:0] base_q;
	logic [1:0] dsel_q;
	logic [15:0] qv_q [4];
	logic dstart_q;
	logic div_done_q;
	logic [1:0] st_c;
	logic [16:0] vc0, vc1, vc2;
	logic [18:0] vc;
	logic [1:0] fm, a, b, c;
	logic side;
	logic [7:0] ta, tb;
	logic [DivW-1:0] dividend;
	logic [7:0] divisor;
	logic dbusy;
	logic [DivW-1:0] quo;
	logic [2:0] cn;
	logic swap;
	logic [15:0] pos [3];
	logic di, dj;
	logic [7:0] ci_n, cj_n;
	logic [31:0] idx_sum;

	assign vc0 = 17'(tess_counts[7:0]) * 17'(tess_counts[15:8]);
	assign vc1 = 17'(tess_counts[7:0]) * 17'(tess_counts[23:16]);
	assign vc2 = 17'(tess_counts[15:8]) * 17'(tess_counts[23:16]);
	assign vc = (19'(vc0) + 19'(vc1) + 19'(vc2)) << 1;

	always_comb begin
		if (size_x == 16'd0 || size_y == 16'd0 || size_z == 16'd0) st_c = ST_ZERO_SIZE;
		else if (tess_counts[7:0] < 8'd2 || tess_counts[15:8] < 8'd2 ||
			tess_counts[23:16] < 8'd2) st_c = ST_LOW_COUNT;
		else if (vc > 19'(MaxVertices)) st_c = ST_TOO_MANY;
		else st_c = ST_OK;
	end

	always_comb begin
		fm = (face_q >= 3'd3) ? 2'(face_q - 3'd3) : face_q[1:0];
		if (fm == 2'd3) fm = 2'd2;
		side = face_q >= 3'd3;
		a = (fm == 2'd2) ? 2'd1 : 2'd0;
		b = (fm == 2'd0) ? 2'd1 : 2'd2;
		c = 2'(3'd3 - 3'(a) - 3'(b));
		ta = ts_q[a];
		tb = ts_q[b];
	end

	always_comb begin
		case (dsel_q)
			2'd0: begin dividend = DivW'(ci_q) * DivW'(sz_q[a]); divisor = ta - 8'd1; end
			2'd1: begin dividend = DivW'(cj_q) * DivW'(sz_q[b]); divisor = tb - 8'd1; end
			2'd2: begin dividend = DivW'(ci_q) * DivW'(tx_q[a]); divisor = ta - 8'd1; end
			default: begin dividend = DivW'(cj_q) * DivW'(tx_q[b]); divisor = tb - 8'd1; end
		endcase
	end

	tbmg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart_q), .dividend(dividend),
		.divisor(divisor), .busy(dbusy), .quotient(quo)
	);

	logic dbusy_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsel_q <= '0;
			dstart_q <= 1'b0;
			dbusy_q <= 1'b0;
			div_done_q <= 1'b0;
		end else begin
			dbusy_q <= dbusy;
			dstart_q <= 1'b0;
			div_done_q <= 1'b0;
			if (cmd.start_div) begin
				dsel_q <= 2'd0;
				dstart_q <= 1'b1;
			end else if (dbusy_q && !dbusy && !dstart_q) begin
				if (dsel_q == 2'd3) begin
					div_done_q <= 1'b1;
				end else begin
					dsel_q <= dsel_q + 2'd1;
					dstart_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dbusy_q && !dbusy) qv_q[dsel_q] <= quo[15:0];
	end

	always_comb begin
		pos[0] = '0;
		pos[1] = '0;
		pos[2] = '0;
		pos[a] = sat16(19'(signed'({3'b0, qv_q[0]})) - 19'(signed'({3'b0, sz_q[a][15:1]})));
		pos[b] = sat16(19'(signed'({3'b0, qv_q[1]})) - 19'(signed'({3'b0, sz_q[b][15:1]})));
		pos[c] = side ? {1'b0, sz_q[c][15:1]} : 16'(-{1'b0, sz_q[c][15:1]});
	end

	always_comb begin
		cn = (corner_q > 3'd5) ? 3'd5 : corner_q;
		swap = face_q[0] ^ inside_q;
		if (swap) begin
			case (cn)
				3'd1: cn = 3'd2;
				3'd2: cn = 3'd1;
				3'd4: cn = 3'd5;
				3'd5: cn = 3'd4;
				default: ;
			endcase
		end
		case (cn)
			3'd0: begin di = 1'b0; dj = 1'b0; end
			3'd1: begin di = 1'b0; dj = 1'b1; end
			3'd2: begin di = 1'b1; dj = 1'b0; end
			3'd3: begin di = 1'b0; dj = 1'b1; end
			3'd4: begin di = 1'b1; dj = 1'b1; end
			default: begin di = 1'b1; dj = 1'b0; end
		endcase
		ci_n = ci_q + 8'(di);
		cj_n = cj_q + 8'(dj);
		idx_sum = 32'(ci_n) + 32'(cj_n) * 32'(ta) + 32'(base_q);
	end

	assign sts.phase_idx = phase_q;
	assign sts.status = st_c;
	assign sts.div_done = div_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_q <= '0; phase_q <= 1'b0; ci_q <= '0; cj_q <= '0;
			corner_q <= '0; base_q <= '0; done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cmd.latch) begin
				face_q <= '0; phase_q <= 1'b0; ci_q <= '0; cj_q <= '0;
				corner_q <= '0; base_q <= '0;
			end else if (cmd.emit_vtx) begin
				if (ci_q + 8'd1 >= ta) begin
					ci_q <= '0;
					if (cj_q + 8'd1 >= tb) begin
						cj_q <= '0; phase_q <= 1'b1; corner_q <= '0;
					end else cj_q <= cj_q + 8'd1;
				end else ci_q <= ci_q + 8'd1;
			end else if (cmd.emit_idx) begin
				if (corner_q + 3'd1 >= 3'd6) begin
					corner_q <= '0;
					if (cj_q + 8'd1 >= tb - 8'd1) begin
						cj_q <= '0;
						if (ci_q + 8'd1 >= ta - 8'd1) begin
							ci_q <= '0; phase_q <= 1'b0;
							if (face_q + 3'd1 >= 3'd6) begin
								face_q <= '0; base_q <= '0; done <= 1'b1;
							end else begin
								face_q <= face_q + 3'd1;
								base_q <= base_q + 16'(ta) * 16'(tb);
							end
						end else ci_q <= ci_q + 8'd1;
					end else cj_q <= cj_q + 8'd1;
				end else corner_q <= corner_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			sz_q[0] <= size_x; sz_q[1] <= size_y; sz_q[2] <= size_z;
			for (int k = 0; k < 3; k++) begin
				ts_q[k] <= tess_counts[8*k +: 8];
				tx_q[k] <= tex_scale[16*k +: 16];
			end
			inside_q <= inside_out;
		end
		if (cmd.err) begin
			elem <= '0;
			elem.status <= st_c;
			elem.last <= 1'b1;
		end else if (cmd.emit_vtx) begin
			elem <= '0;
			elem.pos_x <= pos[0];
			elem.pos_y <= pos[1];
			elem.pos_z <= pos[2];
			elem.normal_axis <= c;
			elem.normal_sign <= side ^ inside_q;
			elem.tex_u <= qv_q[2];
			elem.tex_v <= qv_q[3];
		end else if (cmd.emit_idx) begin
			elem <= '0;
			elem.kind <= 1'b1;
			elem.index_value <= idx_sum[15:0];
			elem.last <= (corner_q + 3'd1 >= 3'd6) && (cj_q + 8'd1 >= tb - 8'd1) &&
				(ci_q + 8'd1 >= ta - 8'd1) && (face_q + 3'd1 >= 3'd6);
		end
	end
endmodule

// File: rtl/core/tbmg_ctrl.sv
// Controller state machine: input handshake, sequencing, output register valid.
// Depends on tbmg_pkg.
module tbmg_ctrl import tbmg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic restart,
	input logic out_fire,
	input sts_t sts,
	input logic done,
	output logic in_ready,
	output logic out_valid,
	output cmd_t cmd
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001, S_RUN = 6'b000010, S_LATCH = 6'b000100,
		S_DIV = 6'b001000, S_EMIT = 6'b010000, S_OUT = 6'b100000
	} state_t;
	state_t state_q;
	logic running_q;

	assign in_ready = (state_q == S_IDLE || state_q == S_RUN);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE, S_RUN: begin
				cmd.latch = in_fire && restart;
				cmd.err = in_fire && restart && sts.status != ST_OK;
			end
			S_LATCH: begin
				cmd.start_div = !sts.phase_idx;
				cmd.emit_idx = sts.phase_idx;
			end
			S_DIV: cmd.emit_vtx = sts.div_done;
			S_EMIT, S_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			running_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_fire) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE, S_RUN: begin
					if (in_fire && restart) begin
						if (sts.status != ST_OK) begin
							running_q <= 1'b0;
							out_valid <= 1'b1;
							state_q <= S_OUT;
						end else begin
							running_q <= 1'b1;
							state_q <= S_LATCH;
						end
					end else if (in_fire && running_q) begin
						state_q <= S_LATCH;
					end
				end
				S_LATCH: state_q <= sts.phase_idx ? S_EMIT : S_DIV;
				S_DIV: if (sts.div_done) state_q <= S_EMIT;
				S_EMIT: begin
					if (done) running_q <= 1'b0;
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (out_fire || !out_valid) state_q <= running_q ? S_RUN : S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/core/tessellated_box_mesh_generator_core.sv
// Tessellated box mesh generator, top level: config registers and stream ports.
// Depends on tbmg_pkg, tbmg_ctrl, tbmg_dp, tbmg_div.
// Index words need no division; each vertex word takes four divisions of 24 quotient bits.
// Throughput: one word in flight; next word accepted once the previous is taken.
// Reset: asynchronous, active low; idle, registers at defaults.
module tessellated_box_mesh_generator_core import tbmg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata, // restart
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [103:0] m_axis_tdata, // status, pos_x, pos_y, pos_z, normal_axis,
	                                   // normal_sign, tex_u, tex_v, index_value
	output logic m_axis_tuser,         // kind
	output logic m_axis_tlast,         // last
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [47:0] cfg_data
);
	logic [15:0] size_x_q, size_y_q, size_z_q;
	logic [23:0] tess_q;
	logic [47:0] tex_q;
	logic inside_q;
	cmd_t cmd;
	sts_t sts;
	elem_t elem;
	logic done;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= 16'd256; size_y_q <= 16'd256; size_z_q <= 16'd256;
			tess_q <= 24'd131586; tex_q <= 48'd1099528405248; inside_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SIZE_X: size_x_q <= cfg_data[15:0];
				REG_SIZE_Y: size_y_q <= cfg_data[15:0];
				REG_SIZE_Z: size_z_q <= cfg_data[15:0];
				REG_TESS: tess_q <= cfg_data[23:0];
				REG_TEX: tex_q <= cfg_data;
				REG_INSIDE: inside_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tbmg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_axis_tvalid && s_axis_tready),
		.restart(s_axis_tdata[0]), .out_fire(m_axis_tvalid && m_axis_tready),
		.sts(sts), .done(done), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid),
		.cmd(cmd)
	);

	tbmg_dp u_dp (
		.clk(clk), .arst_n(arst_n), .size_x(size_x_q), .size_y(size_y_q),
		.size_z(size_z_q), .tess_counts(tess_q), .tex_scale(tex_q),
		.inside_out(inside_q), .cmd(cmd), .sts(sts), .elem(elem), .done(done)
	);

	assign m_axis_tuser = elem.kind;
	assign m_axis_tlast = elem.last;
	assign m_axis_tdata = {3'd0, elem.index_value, elem.tex_v, elem.tex_u,
		elem.normal_sign, elem.normal_axis, elem.pos_z, elem.pos_y, elem.pos_x,
		elem.status};
endmodule

// File: rtl/core/tbmg_checker.sv
// Port-level checker for the mesh generator, bound to the top level.
// Depends on tbmg_pkg.
module tbmg_checker import tbmg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic m_axis_tuser,
	input logic m_axis_tlast,
	input logic [103:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken with word pending");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tlast && !m_axis_tuser)
		else $error("error word without last");
	a_idx_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[84:0] == 85'd0)
		else $error("index word carries vertex fields");
endmodule

bind tessellated_box_mesh_generator_core tbmg_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tuser(m_axis_tuser),
	.m_axis_tlast(m_axis_tlast), .m_axis_tdata(m_axis_tdata)
);
